// ===== hdl/olid_pkg.sv =====
// types, constants and codes shared by the ordered list block
`default_nettype none
package olid_pkg;

	localparam int CAPACITY = 32;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = 32;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_LIST = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_LIST
	} state_t;

	typedef struct packed {
		op_t                   op;
		logic signed [DW-1:0]  value;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic signed [DW-1:0]  entry;
		logic                  last;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/olid_store.sv =====
// entry store: one write port, one read port with registered data
`default_nettype none
module olid_store (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [olid_pkg::AW-1:0]     wr_addr,
	input  wire logic [olid_pkg::DW-1:0]     wr_data,
	input  wire logic [olid_pkg::AW-1:0]     rd_addr,
	output      logic [olid_pkg::DW-1:0]     rd_data
);
	import olid_pkg::*;

	logic [DW-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hdl/ordered_list_insert_delete.sv =====
// ordered list of signed words: add at front, delete first match, list newest first
//
// An item is taken when start is high and busy is low. Every result is shown for one
// cycle with done high and cannot be held off, so the receiver must take it then.
// An add, and any delete or list on an empty list, leaves busy low and gives its
// single result in the next cycle; an unknown op gives nothing. A delete walks the
// store from the newest entry through the one read port, one entry per cycle, with a
// single comparator, then moves each entry newer than the match down one place,
// one per cycle, keeping busy high until the last entry is written back; a delete
// that finds no match ends once the oldest entry has been compared. A list gives
// one result per cycle, newest first, once the registered read data arrives, and
// marks the oldest with last. The store needs no clearing after reset.
`default_nettype none
module ordered_list_insert_delete (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire olid_pkg::req_t req,
	output      logic           busy,
	output      logic           done,
	output      olid_pkg::res_t res
);
	import olid_pkg::*;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [DW-1:0]     value_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     rem_q;
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic              done_q;
	res_t              res_q;

	logic              accept;
	logic              iss;
	logic              hit;
	logic              miss_end;
	logic              list_end;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DW-1:0]     wr_data;
	logic [DW-1:0]     rd_data;
	logic              emit;
	res_t              emit_res;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign hit      = (state_q == S_SEARCH) && vld_s1 && (rd_data == value_q);
	assign miss_end = (state_q == S_SEARCH) && vld_s1 && !hit && (addr_s1 == '0);
	assign list_end = (state_q == S_LIST) && vld_s1 && (addr_s1 == '0);

	olid_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && count_q != '0) begin
					if (req.op == OP_DEL) begin
						state_d = S_SEARCH;
					end else if (req.op == OP_LIST) begin
						state_d = S_LIST;
					end
				end
			end
			S_SEARCH: begin
				if (hit) begin
					state_d = S_SHIFT;
				end else if (miss_end) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (rem_q == '0) begin
					state_d = S_IDLE;
				end
			end
			S_LIST: begin
				if (list_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath control and result beats
	always_comb begin
		iss      = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = count_q[AW-1:0];
		wr_data  = req.value;
		emit     = 1'b0;
		emit_res = '{status: ST_OK, entry: '0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.op)
						OP_ADD: begin
							emit = 1'b1;
							if (count_q >= CW'(CAPACITY)) begin
								emit_res.status = ST_FULL;
							end else begin
								wr_en = 1'b1;
							end
						end
						OP_DEL, OP_LIST: begin
							if (count_q == '0) begin
								emit            = 1'b1;
								emit_res.status = ST_EMPTY;
							end
						end
						OP_NONE: ;
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				iss = (rem_q != '0) && !hit;
				if (miss_end) begin
					emit            = 1'b1;
					emit_res.status = ST_NOTFOUND;
				end
			end
			S_SHIFT: begin
				iss = (rem_q != '0);
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1 - AW'(1);
					wr_data = rd_data;
				end
				if (rem_q == '0) begin
					emit = 1'b1;
				end
			end
			S_LIST: begin
				iss = (rem_q != '0);
				if (vld_s1) begin
					emit           = 1'b1;
					emit_res.entry = rd_data;
					emit_res.last  = (addr_s1 == '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= iss;
			done_q  <= emit;
			if (accept && req.op == OP_ADD && count_q < CW'(CAPACITY)) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_SHIFT && rem_q == '0) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				rem_q <= count_q;
			end else if (hit) begin
				rem_q <= count_q - CW'(addr_s1) - CW'(1);
			end else if (iss) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[AW-1:0];
		res_q   <= emit_res;
		if (accept) begin
			value_q <= req.value;
			ptr_q   <= count_q - CW'(1);
		end else if (hit) begin
			ptr_q <= CW'(addr_s1) + CW'(1);
		end else if (iss) begin
			if (state_q == S_SHIFT) begin
				ptr_q <= ptr_q + CW'(1);
			end else begin
				ptr_q <= ptr_q - CW'(1);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q - $past(count_q) == CW'(1)) || ($past(count_q) - count_q == CW'(1))))
		else $error("entry count moved by more than one");

	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status != ST_OK) |-> (res_q.entry == '0))
		else $error("non-ok beat carries an entry");

	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q != S_IDLE))
		else $error("read data pending while idle");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_SHIFT) |-> (CW'(wr_addr) < count_q))
		else $error("shift writes beyond the list");
`endif

endmodule
`default_nettype wire
